// File: rtl/dda_pkg.sv
// Shared types and constants for the grid ray traversal block.
`default_nettype none

package dda_pkg;

    localparam int CELL_W = 6;
    localparam int DIST_W = 24;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam int DEF_MAP_WIDTH  = 64;
    localparam int DEF_MAP_HEIGHT = 64;
    localparam int DEF_MAX_STEPS  = 128;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_RAY,
        OP_RAY_OFF
    } op_t;

    typedef enum logic [1:0] {
        ST_WALL  = 2'd0,
        ST_LEFT  = 2'd1,
        ST_LIMIT = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        WS_CLEAR,
        WS_IDLE,
        WS_WALK
    } walk_state_t;

    typedef struct packed {
        op_t               op;
        logic [CELL_W-1:0] cell_x;
        logic [CELL_W-1:0] cell_y;
        logic              is_wall;
        logic [DIST_W-1:0] side_dist_x;
        logic [DIST_W-1:0] side_dist_y;
        logic [DIST_W-1:0] delta_dist_x;
        logic [DIST_W-1:0] delta_dist_y;
        logic              step_x_neg;
        logic              step_y_neg;
    } item_t;

endpackage

`default_nettype wire

// File: rtl/dda_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dda_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/dda_front.sv
// Front end: accepts input beats, classifies them and drops off-map writes.
`default_nettype none

module dda_front import dda_pkg::*; #(
    parameter int MAP_WIDTH  = DEF_MAP_WIDTH,
    parameter int MAP_HEIGHT = DEF_MAP_HEIGHT
) (
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              kind,
    input  wire logic [CELL_W-1:0] cell_x,
    input  wire logic [CELL_W-1:0] cell_y,
    input  wire logic              is_wall,
    input  wire logic [DIST_W-1:0] side_dist_x,
    input  wire logic [DIST_W-1:0] side_dist_y,
    input  wire logic [DIST_W-1:0] delta_dist_x,
    input  wire logic [DIST_W-1:0] delta_dist_y,
    input  wire logic              step_x_neg,
    input  wire logic              step_y_neg,
    input  wire logic              clearing,
    input  wire logic              q_full,
    output logic                   push,
    output item_t                  push_item
);

    logic on_map;

    assign on_map = (int'(cell_x) < MAP_WIDTH) && (int'(cell_y) < MAP_HEIGHT);
    assign in_ready = !clearing && !q_full;

    always_comb
    begin
        push_item.cell_x       = cell_x;
        push_item.cell_y       = cell_y;
        push_item.is_wall      = is_wall;
        push_item.side_dist_x  = side_dist_x;
        push_item.side_dist_y  = side_dist_y;
        push_item.delta_dist_x = delta_dist_x;
        push_item.delta_dist_y = delta_dist_y;
        push_item.step_x_neg   = step_x_neg;
        push_item.step_y_neg   = step_y_neg;
        if (!kind)
        begin
            push_item.op = OP_WRITE;
        end
        else if (on_map)
        begin
            push_item.op = OP_RAY;
        end
        else
        begin
            push_item.op = OP_RAY_OFF;
        end
        // drop writes that fall outside the map
        push = in_valid && in_ready && (kind || on_map);
    end

endmodule

`default_nettype wire

// File: rtl/dda_queue.sv
// Short register queue between the front end and the walker.
`default_nettype none

module dda_queue import dda_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  item_t     push_item,
    output logic      full,
    input  wire logic pop,
    output logic      empty,
    output item_t     head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t          slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/dda_walk.sv
// Back end: map clear pass, map writes, the ray walk and the result register.
`default_nettype none

module dda_walk import dda_pkg::*; #(
    parameter int MAP_WIDTH  = DEF_MAP_WIDTH,
    parameter int MAP_HEIGHT = DEF_MAP_HEIGHT,
    parameter int MAX_STEPS  = DEF_MAX_STEPS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_empty,
    input  item_t                   q_item,
    output logic                    q_pop,
    output logic                    clearing,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [CELL_W-1:0]       hit_x,
    output logic [CELL_W-1:0]       hit_y,
    output logic                    side,
    output logic [DIST_W-1:0]       final_dist_x,
    output logic [DIST_W-1:0]       final_dist_y,
    output logic [1:0]              status
);

    localparam int XW    = $clog2(MAP_WIDTH);
    localparam int YW    = $clog2(MAP_HEIGHT);
    localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(MAX_STEPS + 1);

    walk_state_t       state_reg, state_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    logic [XW-1:0]     x_reg, x_next;
    logic [YW-1:0]     y_reg, y_next;
    logic [DIST_W-1:0] dx_reg, dx_next;
    logic [DIST_W-1:0] dy_reg, dy_next;
    logic [DIST_W-1:0] ddx_reg, ddx_next;
    logic [DIST_W-1:0] ddy_reg, ddy_next;
    logic              sxn_reg, sxn_next;
    logic              syn_reg, syn_next;
    logic              side_reg, side_next;
    logic [SW-1:0]     steps_reg, steps_next;
    logic              pend_reg, pend_next;

    logic              out_valid_reg, out_valid_next;
    logic [CELL_W-1:0] hit_x_reg;
    logic [CELL_W-1:0] hit_y_reg;
    logic              side_out_reg;
    logic [DIST_W-1:0] fdx_reg;
    logic [DIST_W-1:0] fdy_reg;
    status_t           status_reg;

    logic              res_load;
    logic [CELL_W-1:0] res_x;
    logic [CELL_W-1:0] res_y;
    logic              res_side;
    logic [DIST_W-1:0] res_dx;
    logic [DIST_W-1:0] res_dy;
    status_t           res_status;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic              wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              rd_data;

    logic              out_free;
    logic              go_x;
    logic [DIST_W:0]   sum_x;
    logic [DIST_W:0]   sum_y;
    logic [DIST_W-1:0] sat_x;
    logic [DIST_W-1:0] sat_y;
    logic              lim_x;
    logic              lim_y;
    logic              leave;
    logic [XW-1:0]     nx;
    logic [YW-1:0]     ny;
    logic [DIST_W-1:0] ndx;
    logic [DIST_W-1:0] ndy;

    dda_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign clearing = (state_reg == WS_CLEAR);

    assign go_x  = dx_reg < dy_reg;
    assign sum_x = {1'b0, dx_reg} + {1'b0, ddx_reg};
    assign sum_y = {1'b0, dy_reg} + {1'b0, ddy_reg};
    assign sat_x = sum_x[DIST_W] ? DIST_MAX : sum_x[DIST_W-1:0];
    assign sat_y = sum_y[DIST_W] ? DIST_MAX : sum_y[DIST_W-1:0];
    assign lim_x = sxn_reg ? (x_reg == '0) : (x_reg == XW'(MAP_WIDTH - 1));
    assign lim_y = syn_reg ? (y_reg == '0) : (y_reg == YW'(MAP_HEIGHT - 1));
    assign leave = go_x ? lim_x : lim_y;
    assign nx    = go_x ? (sxn_reg ? x_reg - XW'(1) : x_reg + XW'(1)) : x_reg;
    assign ny    = go_x ? y_reg : (syn_reg ? y_reg - YW'(1) : y_reg + YW'(1));
    assign ndx   = go_x ? sat_x : dx_reg;
    assign ndy   = go_x ? dy_reg : sat_y;

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        ddx_next      = ddx_reg;
        ddy_next      = ddy_reg;
        sxn_next      = sxn_reg;
        syn_next      = syn_reg;
        side_next     = side_reg;
        steps_next    = steps_reg;
        pend_next     = pend_reg;
        q_pop         = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = clr_addr_reg;
        wr_data       = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = AW'(AW'(ny) * AW'(MAP_WIDTH) + AW'(nx));
        res_load      = 1'b0;
        res_x         = CELL_W'(x_reg);
        res_y         = CELL_W'(y_reg);
        res_side      = side_reg;
        res_dx        = dx_reg;
        res_dy        = dy_reg;
        res_status    = ST_WALL;

        case (state_reg)
            WS_CLEAR:
            begin
                wr_en = 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = WS_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end
            WS_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_item.op)
                        OP_WRITE:
                        begin
                            q_pop   = 1'b1;
                            wr_en   = 1'b1;
                            wr_addr = AW'(AW'(YW'(q_item.cell_y)) * AW'(MAP_WIDTH)
                                      + AW'(XW'(q_item.cell_x)));
                            wr_data = q_item.is_wall;
                        end
                        OP_RAY_OFF:
                        begin
                            if (out_free)
                            begin
                                q_pop      = 1'b1;
                                res_load   = 1'b1;
                                res_x      = q_item.cell_x;
                                res_y      = q_item.cell_y;
                                res_side   = 1'b0;
                                res_dx     = q_item.side_dist_x;
                                res_dy     = q_item.side_dist_y;
                                res_status = ST_LEFT;
                            end
                        end
                        OP_RAY:
                        begin
                            q_pop      = 1'b1;
                            x_next     = XW'(q_item.cell_x);
                            y_next     = YW'(q_item.cell_y);
                            dx_next    = q_item.side_dist_x;
                            dy_next    = q_item.side_dist_y;
                            ddx_next   = q_item.delta_dist_x;
                            ddy_next   = q_item.delta_dist_y;
                            sxn_next   = q_item.step_x_neg;
                            syn_next   = q_item.step_y_neg;
                            side_next  = 1'b0;
                            steps_next = '0;
                            pend_next  = 1'b0;
                            state_next = WS_WALK;
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            WS_WALK:
            begin
                if (pend_reg && rd_data)
                begin
                    res_status = ST_WALL;
                    if (out_free)
                    begin
                        res_load   = 1'b1;
                        state_next = WS_IDLE;
                    end
                end
                else if (steps_reg == SW'(MAX_STEPS))
                begin
                    res_status = ST_LIMIT;
                    if (out_free)
                    begin
                        res_load   = 1'b1;
                        state_next = WS_IDLE;
                    end
                end
                else if (leave)
                begin
                    res_status = ST_LEFT;
                    res_side   = !go_x;
                    res_dx     = ndx;
                    res_dy     = ndy;
                    if (out_free)
                    begin
                        res_load   = 1'b1;
                        state_next = WS_IDLE;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    x_next     = nx;
                    y_next     = ny;
                    dx_next    = ndx;
                    dy_next    = ndy;
                    side_next  = !go_x;
                    steps_next = steps_reg + SW'(1);
                    pend_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = WS_IDLE;
            end
        endcase

        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= WS_CLEAR;
            clr_addr_reg  <= '0;
            steps_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            steps_reg     <= steps_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        ddx_reg  <= ddx_next;
        ddy_reg  <= ddy_next;
        sxn_reg  <= sxn_next;
        syn_reg  <= syn_next;
        side_reg <= side_next;
        if (res_load)
        begin
            hit_x_reg    <= res_x;
            hit_y_reg    <= res_y;
            side_out_reg <= res_side;
            fdx_reg      <= res_dx;
            fdy_reg      <= res_dy;
            status_reg   <= res_status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit_x        = hit_x_reg;
    assign hit_y        = hit_y_reg;
    assign side         = side_out_reg;
    assign final_dist_x = fdx_reg;
    assign final_dist_y = fdy_reg;
    assign status       = status_reg;

`ifndef ASSERT_OFF
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        steps_reg <= SW'(MAX_STEPS))
        else $error("step count past bound");

    a_cell_on_map: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == WS_WALK) |-> (int'(x_reg) < MAP_WIDTH && int'(y_reg) < MAP_HEIGHT))
        else $error("walk cell off the map");

    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == WS_CLEAR) |-> (!q_pop && !res_load))
        else $error("queue popped during map clear");
`endif

endmodule

`default_nettype wire

// File: rtl/dda_grid_ray_traversal.sv
// Top level of the grid ray traversal block: front end, queue and walker.
//
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------------
//  in      | in_valid/in_ready   | kind cell_x cell_y is_wall side_dist_x/y
//          |                     | delta_dist_x/y step_x_neg step_y_neg
//  out     | out_valid/out_ready | hit_x hit_y side final_dist_x/y status
//
// After reset the map is cleared one cell per cycle, all MAP_WIDTH*MAP_HEIGHT cells
// (4096 by default); in_ready stays low until that pass ends.
// A map write is applied by the walker straight from idle; a ray walks N steps,
// N at most MAX_STEPS, one step per cycle through the map RAM's registered read.
// Input beats queue in a two-entry buffer; a result waits in the output register
// and the walker holds its final state while out_ready is low.
`default_nettype none

module dda_grid_ray_traversal import dda_pkg::*; #(
    parameter int MAP_WIDTH  = DEF_MAP_WIDTH,
    parameter int MAP_HEIGHT = DEF_MAP_HEIGHT,
    parameter int MAX_STEPS  = DEF_MAX_STEPS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              kind,
    input  wire logic [CELL_W-1:0] cell_x,
    input  wire logic [CELL_W-1:0] cell_y,
    input  wire logic              is_wall,
    input  wire logic [DIST_W-1:0] side_dist_x,
    input  wire logic [DIST_W-1:0] side_dist_y,
    input  wire logic [DIST_W-1:0] delta_dist_x,
    input  wire logic [DIST_W-1:0] delta_dist_y,
    input  wire logic              step_x_neg,
    input  wire logic              step_y_neg,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [CELL_W-1:0]      hit_x,
    output logic [CELL_W-1:0]      hit_y,
    output logic                   side,
    output logic [DIST_W-1:0]      final_dist_x,
    output logic [DIST_W-1:0]      final_dist_y,
    output logic [1:0]             status
);

    logic  clearing;
    logic  q_full;
    logic  q_empty;
    logic  push;
    logic  pop;
    item_t push_item;
    item_t head;

    dda_front #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT)
    ) u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .is_wall      (is_wall),
        .side_dist_x  (side_dist_x),
        .side_dist_y  (side_dist_y),
        .delta_dist_x (delta_dist_x),
        .delta_dist_y (delta_dist_y),
        .step_x_neg   (step_x_neg),
        .step_y_neg   (step_y_neg),
        .clearing     (clearing),
        .q_full       (q_full),
        .push         (push),
        .push_item    (push_item)
    );

    dda_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .head      (head)
    );

    dda_walk #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT),
        .MAX_STEPS  (MAX_STEPS)
    ) u_walk (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_item       (head),
        .q_pop        (pop),
        .clearing     (clearing),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit_x        (hit_x),
        .hit_y        (hit_y),
        .side         (side),
        .final_dist_x (final_dist_x),
        .final_dist_y (final_dist_y),
        .status       (status)
    );

endmodule

`default_nettype wire

// File: verif/dda_grid_ray_traversal_test.sv
// Self-checking testbench for the grid ray traversal block: directed and random map/ray traffic.
`default_nettype none

module dda_grid_ray_traversal_test import dda_pkg::*;;

    localparam int MAP_W        = DEF_MAP_WIDTH;
    localparam int MAP_H        = DEF_MAP_HEIGHT;
    localparam int STEP_BOUND   = DEF_MAX_STEPS;
    localparam int RANDOM_ITEMS = 1150;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE       = STEP_BOUND + 64;
    localparam int CYCLE_LIMIT  = 1000000;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_RAY   = 1'b1;
    localparam logic SIDE_X     = 1'b0;
    localparam logic SIDE_Y     = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [CELL_W-1:0] cell_x;
        logic [CELL_W-1:0] cell_y;
        logic              is_wall;
        logic [DIST_W-1:0] side_dist_x;
        logic [DIST_W-1:0] side_dist_y;
        logic [DIST_W-1:0] delta_dist_x;
        logic [DIST_W-1:0] delta_dist_y;
        logic              step_x_neg;
        logic              step_y_neg;
    } grid_beat_t;

    typedef struct packed {
        logic [CELL_W-1:0] hit_x;
        logic [CELL_W-1:0] hit_y;
        logic              side;
        logic [DIST_W-1:0] dist_x;
        logic [DIST_W-1:0] dist_y;
        logic [1:0]        status;
    } ray_hit_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_ready;
    logic              kind         = KIND_WRITE;
    logic [CELL_W-1:0] cell_x       = '0;
    logic [CELL_W-1:0] cell_y       = '0;
    logic              is_wall      = 1'b0;
    logic [DIST_W-1:0] side_dist_x  = '0;
    logic [DIST_W-1:0] side_dist_y  = '0;
    logic [DIST_W-1:0] delta_dist_x = '0;
    logic [DIST_W-1:0] delta_dist_y = '0;
    logic              step_x_neg   = 1'b0;
    logic              step_y_neg   = 1'b0;
    logic              out_valid;
    logic              out_ready    = 1'b0;
    logic [CELL_W-1:0] hit_x;
    logic [CELL_W-1:0] hit_y;
    logic              side;
    logic [DIST_W-1:0] final_dist_x;
    logic [DIST_W-1:0] final_dist_y;
    logic [1:0]        status;

    bit          wall_cells [0:MAP_W*MAP_H-1];
    ray_hit_t    expected_hits [$];
    ray_hit_t    seen_hit;
    int          errors       = 0;
    int          writes_sent  = 0;
    int          rays_sent    = 0;
    int          wall_hits    = 0;
    int          exits        = 0;
    int          bound_hits   = 0;
    int          burst_left   = 0;
    bit          steady       = 1'b0;
    int unsigned cycle_count  = 0;
    bit          hold_ask     = 1'b0;
    bit          hold_ack     = 1'b0;
    int          hold_left    = 0;
    int          mode_left    = 0;
    int          ready_mode   = 0;

    dda_grid_ray_traversal u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .is_wall      (is_wall),
        .side_dist_x  (side_dist_x),
        .side_dist_y  (side_dist_y),
        .delta_dist_x (delta_dist_x),
        .delta_dist_y (delta_dist_y),
        .step_x_neg   (step_x_neg),
        .step_y_neg   (step_y_neg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit_x        (hit_x),
        .hit_y        (hit_y),
        .side         (side),
        .final_dist_x (final_dist_x),
        .final_dist_y (final_dist_y),
        .status       (status)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic logic [DIST_W-1:0] add_sat(input logic [DIST_W-1:0] a,
                                                  input logic [DIST_W-1:0] b);
        logic [DIST_W:0] sum;
        sum = a + b;
        return sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
    endfunction

    function automatic bit on_map(input int x, input int y);
        return x >= 0 && x < MAP_W && y >= 0 && y < MAP_H;
    endfunction

    function automatic ray_hit_t trace_ray(input grid_beat_t b);
        int                x;
        int                y;
        int                nx;
        int                ny;
        int                sx;
        int                sy;
        int                steps;
        bit                done;
        logic [DIST_W-1:0] dx;
        logic [DIST_W-1:0] dy;
        logic              last_side;
        status_t           st;
        ray_hit_t          r;
        x         = int'(b.cell_x);
        y         = int'(b.cell_y);
        dx        = b.side_dist_x;
        dy        = b.side_dist_y;
        sx        = b.step_x_neg ? -1 : 1;
        sy        = b.step_y_neg ? -1 : 1;
        last_side = SIDE_X;
        st        = ST_LIMIT;
        done      = 1'b0;
        if (!on_map(x, y))
        begin
            st = ST_LEFT;
        end
        else
        begin
            for (steps = 0; steps < STEP_BOUND && !done; steps++)
            begin
                nx = x;
                ny = y;
                if (dx < dy)
                begin
                    dx        = add_sat(dx, b.delta_dist_x);
                    nx        = x + sx;
                    last_side = SIDE_X;
                end
                else
                begin
                    dy        = add_sat(dy, b.delta_dist_y);
                    ny        = y + sy;
                    last_side = SIDE_Y;
                end
                if (!on_map(nx, ny))
                begin
                    st   = ST_LEFT;
                    done = 1'b1;
                end
                else
                begin
                    x = nx;
                    y = ny;
                    if (wall_cells[y*MAP_W + x])
                    begin
                        st   = ST_WALL;
                        done = 1'b1;
                    end
                end
            end
        end
        r.hit_x  = CELL_W'(x);
        r.hit_y  = CELL_W'(y);
        r.side   = last_side;
        r.dist_x = dx;
        r.dist_y = dy;
        r.status = st;
        return r;
    endfunction

    task automatic apply_beat(input grid_beat_t b);
        if (b.kind == KIND_WRITE)
        begin
            writes_sent++;
            if (on_map(int'(b.cell_x), int'(b.cell_y)))
                wall_cells[int'(b.cell_y)*MAP_W + int'(b.cell_x)] = b.is_wall;
        end
        else
        begin
            rays_sent++;
            expected_hits.push_back(trace_ray(b));
        end
    endtask

    task automatic send_beat(input grid_beat_t b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid     <= 1'b1;
        kind         <= b.kind;
        cell_x       <= b.cell_x;
        cell_y       <= b.cell_y;
        is_wall      <= b.is_wall;
        side_dist_x  <= b.side_dist_x;
        side_dist_y  <= b.side_dist_y;
        delta_dist_x <= b.delta_dist_x;
        delta_dist_y <= b.delta_dist_y;
        step_x_neg   <= b.step_x_neg;
        step_y_neg   <= b.step_y_neg;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        apply_beat(b);
    endtask

    task automatic write_cell(input int x, input int y, input bit w);
        grid_beat_t b;
        b.kind         = KIND_WRITE;
        b.cell_x       = CELL_W'(x);
        b.cell_y       = CELL_W'(y);
        b.is_wall      = w;
        b.side_dist_x  = DIST_W'($urandom());
        b.side_dist_y  = DIST_W'($urandom());
        b.delta_dist_x = DIST_W'($urandom());
        b.delta_dist_y = DIST_W'($urandom());
        b.step_x_neg   = 1'($urandom_range(0, 1));
        b.step_y_neg   = 1'($urandom_range(0, 1));
        send_beat(b);
    endtask

    task automatic cast_ray(input int x, input int y,
                            input logic [DIST_W-1:0] sdx, input logic [DIST_W-1:0] sdy,
                            input logic [DIST_W-1:0] ddx, input logic [DIST_W-1:0] ddy,
                            input bit xneg, input bit yneg);
        grid_beat_t b;
        b.kind         = KIND_RAY;
        b.cell_x       = CELL_W'(x);
        b.cell_y       = CELL_W'(y);
        b.is_wall      = 1'($urandom_range(0, 1));
        b.side_dist_x  = sdx;
        b.side_dist_y  = sdy;
        b.delta_dist_x = ddx;
        b.delta_dist_y = ddy;
        b.step_x_neg   = xneg;
        b.step_y_neg   = yneg;
        send_beat(b);
    endtask

    function automatic logic [DIST_W-1:0] pick_dist();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DIST_MAX;
            2, 3:    return DIST_W'($urandom());
            default: return DIST_W'($urandom_range(32'h100, 32'h30000));
        endcase
    endfunction

    task automatic check_field(input string name, input logic [DIST_W-1:0] want,
                               input logic [DIST_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (status == ST_WALL)
                wall_hits++;
            else if (status == ST_LEFT)
                exits++;
            else
                bound_hits++;
            if (expected_hits.size() == 0)
            begin
                $display("%0t: result with none expected, expected nothing actual (%0d,%0d) %0d",
                         $time, hit_x, hit_y, status);
                errors++;
            end
            else
            begin
                seen_hit = expected_hits.pop_front();
                check_field("hit_x", DIST_W'(seen_hit.hit_x), DIST_W'(hit_x));
                check_field("hit_y", DIST_W'(seen_hit.hit_y), DIST_W'(hit_y));
                check_field("side", DIST_W'(seen_hit.side), DIST_W'(side));
                check_field("final_dist_x", seen_hit.dist_x, final_dist_x);
                check_field("final_dist_y", seen_hit.dist_y, final_dist_y);
                check_field("status", DIST_W'(seen_hit.status), DIST_W'(status));
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_ask != hold_ack)
        begin
            hold_ack  <= hold_ask;
            hold_left <= LONG_HOLD;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(16, 256);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            case (ready_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 3) != 0);
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ((cycle_count % 16) < 10);
            endcase
        end
    end

    task automatic test_open_map_rays();
        cast_ray(0, 20, 24'h000800, 24'h001000, 24'h001000, 24'h001000, 1'b1, 1'b0);
        cast_ray(30, 63, 24'h001000, 24'h001000, '0, '0, 1'b0, 1'b0);
        cast_ray(0, 0, 24'h000800, 24'h001000, 24'h001000, 24'h001000, 1'b0, 1'b0);
        cast_ray(63, 63, DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX, 1'b1, 1'b1);
        cast_ray(10, 40, '0, 24'h000010, '0, 24'h000010, 1'b0, 1'b1);
        cast_ray(63, 0, 24'hFFFFFE, DIST_MAX, 24'h000005, '0, 1'b0, 1'b0);
    endtask

    task automatic test_wall_hits();
        write_cell(0, 0, 1'b1);
        write_cell(63, 63, 1'b1);
        write_cell(63, 0, 1'b1);
        write_cell(0, 63, 1'b1);
        write_cell(40, 5, 1'b1);
        cast_ray(20, 5, 24'h000400, 24'h100000, 24'h000800, 24'h100000, 1'b0, 1'b0);
        cast_ray(0, 10, 24'h100000, 24'h000400, 24'h100000, 24'h000400, 1'b0, 1'b1);
        cast_ray(62, 62, 24'h000800, 24'h001000, 24'h001000, 24'h001000, 1'b0, 1'b0);
        cast_ray(63, 0, 24'h000100, 24'h800000, 24'h000100, 24'h800000, 1'b1, 1'b0);
        write_cell(40, 5, 1'b0);
        cast_ray(20, 5, 24'h000400, 24'h100000, 24'h000800, 24'h100000, 1'b0, 1'b0);
    endtask

    task automatic test_backpressure();
        steady   = 1'b1;
        hold_ask <= ~hold_ask;
        repeat (12)
            cast_ray(0, $urandom_range(1, 62), 24'h000100, 24'h002000,
                     pick_dist(), pick_dist(), 1'b1, 1'($urandom_range(0, 1)));
        steady = 1'b0;
    endtask

    task automatic test_random_scenes();
        int first;
        int near_x;
        int near_y;
        int x0;
        int y0;
        int len;
        int i;
        bit horiz;
        first  = writes_sent + rays_sent;
        near_x = 32;
        near_y = 32;
        while (writes_sent + rays_sent - first < RANDOM_ITEMS)
        begin
            steady = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 3) == 0)
            begin
                x0    = $urandom_range(0, MAP_W-1);
                y0    = $urandom_range(0, MAP_H-1);
                len   = $urandom_range(3, 10);
                horiz = 1'($urandom_range(0, 1));
                for (i = 0; i < len; i++)
                    write_cell(horiz ? x0 + i : x0, horiz ? y0 : y0 + i, 1'b1);
                near_x = x0;
                near_y = y0;
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    near_x = $urandom_range(0, MAP_W-1);
                    near_y = $urandom_range(0, MAP_H-1);
                    write_cell(near_x, near_y, $urandom_range(0, 3) != 0);
                end
            end
            repeat ($urandom_range(4, 16))
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    cast_ray($urandom_range(0, MAP_W-1), $urandom_range(0, MAP_H-1),
                             pick_dist(), pick_dist(), pick_dist(), pick_dist(),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
                else
                begin
                    x0 = (near_x + $urandom_range(0, 12) - 6) & (MAP_W - 1);
                    y0 = (near_y + $urandom_range(0, 12) - 6) & (MAP_H - 1);
                    cast_ray(x0, y0, pick_dist(), pick_dist(), pick_dist(), pick_dist(),
                             x0 > near_x, y0 > near_y);
                end
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, expected_hits.size());
        $display("status: fail");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_open_map_rays();
        test_wall_hits();
        test_backpressure();
        test_random_scenes();
        in_valid <= 1'b0;
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        $display("sent %0d map writes and %0d rays, including a long output stall",
                 writes_sent, rays_sent);
        $display("rays stopped on a wall %0d, off the map %0d, at the step bound %0d",
                 wall_hits, exits, bound_hits);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
